// ===== hdl/regula_falsi_cubic_root_defines.svh =====
// assertion macros for the checker file
`ifndef REGULA_FALSI_CUBIC_ROOT_DEFINES_SVH
`define REGULA_FALSI_CUBIC_ROOT_DEFINES_SVH

// clocked check, quiet while reset is asserted
`define RFCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define RFCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/rfcr_pkg.sv =====
package rfcr_pkg;

  localparam int FracBits     = 16;
  localparam int XW           = 24;
  localparam int FW           = 40;
  localparam int DxW          = XW + 1;
  localparam int DenW         = FW + 1;
  localparam int NumW         = 65;
  localparam int QW           = 25;
  localparam int ItrW         = 5;
  localparam int TolW         = 16;
  localparam int MaxIterBound = 31;
  localparam int MulSplit     = 20;

  localparam logic signed [FW-1:0] FSat = 40'sd274877906943;

  // configuration register indexes
  localparam logic CfgTol   = 1'b0;
  localparam logic CfgLimit = 1'b1;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_NO_SIGN   = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_ZERO_DEN  = 2'd3
  } rfcr_status_e;

  typedef enum logic [1:0] {
    OPD_LEFT,
    OPD_RIGHT,
    OPD_EST
  } rfcr_opd_e;

  typedef enum logic [1:0] {
    ROOT_ZERO,
    ROOT_LEFT,
    ROOT_EST
  } rfcr_root_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FA_SQ, S_FA_CU, S_FB_SQ, S_FB_CU, S_CHECK, S_DEN, S_MUL_LO,
    S_MUL_HI, S_DIV_INIT, S_DIV, S_EST, S_CMP, S_FP_SQ, S_FP_CU, S_SEL, S_DONE
  } rfcr_state_e;

  typedef struct packed {
    logic      load;
    logic      cub_sq;
    logic      cub_cu;
    rfcr_opd_e opd;
    logic      side_sel;
    logic      mul_lo;
    logic      mul_hi;
    logic      div_init;
    logic      div_step;
    logic      est;
    logic      commit;
  } rfcr_cmd_t;

  typedef struct packed {
    logic ends_same;
    logic ends_opp;
    logic den_zero;
    logic converged;
  } rfcr_stat_t;

endpackage

// ===== hdl/rfcr_datapath.sv =====
module rfcr_datapath
  import rfcr_pkg::*;
(
  input  logic                 clk_i,
  input  rfcr_cmd_t            cmd_i,
  input  logic signed [XW-1:0] left_i,
  input  logic signed [XW-1:0] right_i,
  input  logic [TolW-1:0]      tol_i,
  output rfcr_stat_t           stat_o,
  output logic signed [XW-1:0] x0_o,
  output logic signed [XW-1:0] est_o
);

  logic signed [XW-1:0]   x0_q, x1_q, prev_q, next_q;
  logic signed [FW-1:0]   fa_q, fb_q, fp_q;
  logic signed [31:0]     sq_q;
  logic signed [NumW-1:0] acc_q;
  logic [NumW-1:0]        rem_q, dsh_q;
  logic [QW-1:0]          qm_q;
  logic                   qneg_q, qovf_q;

  logic signed [XW-1:0]     opd;
  logic signed [2*XW-1:0]   sq_full;
  logic signed [55:0]       cu_full;
  logic signed [FW-1:0]     cu;
  logic signed [XW+3:0]     nine_x;
  logic signed [FW+1:0]     f_raw;
  logic signed [FW-1:0]     f_val;
  logic signed [DxW-1:0]    dx;
  logic signed [MulSplit:0] mb;
  logic signed [DxW+MulSplit:0] mprod;
  logic signed [DenW-1:0]   den;
  logic [NumW-1:0]          num_mag;
  logic [DenW-1:0]          den_mag;
  logic                     ovf;
  logic [QW-1:0]            q_mag;
  logic signed [QW:0]       q_s;
  logic signed [XW+2:0]     r_full;
  logic signed [XW-1:0]     r_sat;
  logic signed [DxW-1:0]    diff;
  logic [DxW-1:0]           adiff;

  // cubic operand selection
  always_comb begin
    case (cmd_i.opd)
      OPD_LEFT:  opd = x0_q;
      OPD_RIGHT: opd = x1_q;
      default:   opd = prev_q;
    endcase
  end

  // f(x) = floor(floor(x*x)*x) - 9x + 1, floor shifts
  always_comb begin
    sq_full = opd * opd;
    cu_full = sq_q * opd;
    cu      = cu_full[55:FracBits];
    nine_x  = (28'(opd) <<< 3) + 28'(opd);
    f_raw   = 42'(cu) - 42'(nine_x) + (42'sd1 <<< FracBits);
    if (f_raw > 42'(FSat)) begin
      f_val = FSat;
    end else if (f_raw < -42'(FSat)) begin
      f_val = -FSat;
    end else begin
      f_val = f_raw[FW-1:0];
    end
  end

  // numerator partial products on one shared multiplier
  always_comb begin
    dx = DxW'(x1_q) - DxW'(x0_q);
    if (cmd_i.mul_lo) begin
      mb = $signed({1'b0, fa_q[MulSplit-1:0]});
    end else begin
      mb = (MulSplit+1)'($signed(fa_q[FW-1:MulSplit]));
    end
    mprod = dx * mb;
  end

  // divider set-up, magnitudes and overflow test
  always_comb begin
    den     = DenW'(fb_q) - DenW'(fa_q);
    num_mag = acc_q[NumW-1] ? NumW'(-acc_q) : NumW'(acc_q);
    den_mag = den[DenW-1] ? DenW'(-den) : DenW'(den);
    ovf     = {1'b0, num_mag} >= ({25'd0, den_mag} << QW);
  end

  // estimate from quotient, clamped to 24 bits
  always_comb begin
    q_mag  = (qovf_q || qm_q[QW-1]) ? QW'(24'hFFFFFF) : qm_q;
    q_s    = qneg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    r_full = (XW+3)'(x0_q) - (XW+3)'(q_s);
    if (r_full > (XW+3)'(24'sh7FFFFF)) begin
      r_sat = 24'sh7FFFFF;
    end else if (r_full < -(XW+3)'(25'sh0800000)) begin
      r_sat = -24'sh800000;
    end else begin
      r_sat = r_full[XW-1:0];
    end
  end

  // status towards the controller
  always_comb begin
    diff  = DxW'(next_q) - DxW'(prev_q);
    adiff = diff[DxW-1] ? DxW'(-diff) : DxW'(diff);
    stat_o.ends_same = (fa_q != '0) && (fb_q != '0) && (fa_q[FW-1] == fb_q[FW-1]);
    stat_o.ends_opp  = (fa_q != '0) && (fp_q != '0) && (fa_q[FW-1] != fp_q[FW-1]);
    stat_o.den_zero  = (fa_q == fb_q);
    stat_o.converged = adiff < DxW'(tol_i);
  end

  assign x0_o  = x0_q;
  assign est_o = prev_q;

  // interval and function values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= left_i;
      x1_q <= right_i;
    end else if (cmd_i.side_sel) begin
      if (stat_o.ends_opp) begin
        x1_q <= prev_q;
      end else begin
        x0_q <= prev_q;
      end
    end
    if (cmd_i.cub_sq) begin
      sq_q <= sq_full[2*XW-1:FracBits];
    end
    if (cmd_i.cub_cu) begin
      case (cmd_i.opd)
        OPD_LEFT:  fa_q <= f_val;
        OPD_RIGHT: fb_q <= f_val;
        default:   fp_q <= f_val;
      endcase
    end else if (cmd_i.side_sel) begin
      if (stat_o.ends_opp) begin
        fb_q <= fp_q;
      end else begin
        fa_q <= fp_q;
      end
    end
  end

  // product accumulation and restoring division
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      acc_q <= NumW'(mprod);
    end else if (cmd_i.mul_hi) begin
      acc_q <= acc_q + (NumW'(mprod) <<< MulSplit);
    end
    if (cmd_i.div_init) begin
      rem_q  <= num_mag;
      dsh_q  <= {den_mag, 24'd0};
      qm_q   <= '0;
      qneg_q <= acc_q[NumW-1] ^ den[DenW-1];
      qovf_q <= ovf;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        qm_q  <= {qm_q[QW-2:0], 1'b1};
      end else begin
        qm_q  <= {qm_q[QW-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // estimates
  always_ff @(posedge clk_i) begin
    if (cmd_i.est) begin
      next_q <= r_sat;
    end
    if (cmd_i.commit) begin
      prev_q <= next_q;
    end
  end

endmodule

// ===== hdl/rfcr_ctrl.sv =====
module rfcr_ctrl
  import rfcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output logic signed [XW-1:0] m_root_o,
  output logic [ItrW-1:0]      m_iter_o,
  output rfcr_status_e         m_status_o,
  input  logic [ItrW-1:0]      limit_i,
  input  rfcr_stat_t           stat_i,
  input  logic signed [XW-1:0] x0_i,
  input  logic signed [XW-1:0] est_i,
  output rfcr_cmd_t            cmd_o
);

  rfcr_state_e  state_q, state_d;
  logic [ItrW-1:0] itr_q, itr_d;
  logic [ItrW-1:0] cnt_q, cnt_d;
  rfcr_status_e code_q, code_d;
  rfcr_root_e   rsel_q, rsel_d;
  logic         out_load;
  logic [ItrW:0] itr_inc, lim_eff;
  logic signed [XW-1:0] root_sel;

  // limit capped at the bound
  assign lim_eff = (6'(limit_i) > 6'(MaxIterBound)) ? 6'(MaxIterBound) : 6'(limit_i);
  assign itr_inc = 6'(itr_q) + 6'd1;
  assign out_load = (state_q == S_DONE) && (!m_valid_o || m_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (s_valid_i) state_d = S_FA_SQ;
      S_FA_SQ:    state_d = S_FA_CU;
      S_FA_CU:    state_d = S_FB_SQ;
      S_FB_SQ:    state_d = S_FB_CU;
      S_FB_CU:    state_d = S_CHECK;
      S_CHECK:    state_d = stat_i.ends_same ? S_DONE : S_DEN;
      S_DEN:      state_d = stat_i.den_zero ? S_DONE : S_MUL_LO;
      S_MUL_LO:   state_d = S_MUL_HI;
      S_MUL_HI:   state_d = S_DIV_INIT;
      S_DIV_INIT: state_d = S_DIV;
      S_DIV:      if (cnt_q == '0) state_d = S_EST;
      S_EST:      state_d = S_CMP;
      S_CMP: begin
        if (itr_q == '0) begin
          state_d = S_FP_SQ;
        end else if (stat_i.converged || itr_inc >= lim_eff) begin
          state_d = S_DONE;
        end else begin
          state_d = S_FP_SQ;
        end
      end
      S_FP_SQ:    state_d = S_FP_CU;
      S_FP_CU:    state_d = S_SEL;
      S_SEL:      state_d = S_DEN;
      S_DONE:     if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // commands and bookkeeping
  always_comb begin
    cmd_o     = '0;
    cmd_o.opd = OPD_LEFT;
    s_ready_o = 1'b0;
    itr_d     = itr_q;
    cnt_d     = cnt_q;
    code_d    = code_q;
    rsel_d    = rsel_q;
    case (state_q)
      S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = 1'b1;
        itr_d      = '0;
      end
      S_FA_SQ: begin
        cmd_o.cub_sq = 1'b1;
        cmd_o.opd    = OPD_LEFT;
      end
      S_FA_CU: begin
        cmd_o.cub_cu = 1'b1;
        cmd_o.opd    = OPD_LEFT;
      end
      S_FB_SQ: begin
        cmd_o.cub_sq = 1'b1;
        cmd_o.opd    = OPD_RIGHT;
      end
      S_FB_CU: begin
        cmd_o.cub_cu = 1'b1;
        cmd_o.opd    = OPD_RIGHT;
      end
      S_CHECK: begin
        code_d = ST_NO_SIGN;
        rsel_d = ROOT_ZERO;
      end
      S_DEN: begin
        code_d = ST_ZERO_DEN;
        rsel_d = ROOT_LEFT;
      end
      S_MUL_LO: cmd_o.mul_lo = 1'b1;
      S_MUL_HI: cmd_o.mul_hi = 1'b1;
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = ItrW'(QW - 1);
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
      end
      S_EST: cmd_o.est = 1'b1;
      S_CMP: begin
        cmd_o.commit = 1'b1;
        itr_d        = itr_inc[ItrW-1:0];
        rsel_d       = ROOT_EST;
        code_d       = stat_i.converged ? ST_CONVERGED : ST_LIMIT;
      end
      S_FP_SQ: begin
        cmd_o.cub_sq = 1'b1;
        cmd_o.opd    = OPD_EST;
      end
      S_FP_CU: begin
        cmd_o.cub_cu = 1'b1;
        cmd_o.opd    = OPD_EST;
      end
      S_SEL: cmd_o.side_sel = 1'b1;
      default: ;
    endcase
  end

  // result word source
  always_comb begin
    case (rsel_q)
      ROOT_LEFT: root_sel = x0_i;
      ROOT_EST:  root_sel = est_i;
      default:   root_sel = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      itr_q     <= '0;
      cnt_q     <= '0;
      code_q    <= ST_CONVERGED;
      rsel_q    <= ROOT_ZERO;
      m_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      itr_q   <= itr_d;
      cnt_q   <= cnt_d;
      code_q  <= code_d;
      rsel_q  <= rsel_d;
      if (out_load) begin
        m_valid_o <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_o <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_root_o   <= root_sel;
      m_iter_o   <= itr_q;
      m_status_o <= code_q;
    end
  end

endmodule

// ===== hdl/regula_falsi_cubic_root.sv =====
// False position root finder for f(x) = x^3 - 9x + 1 in signed Q7.16.
// Input stream: one word holds an interval, left end in bits 23:0 and right
// end in bits 47:24. Output stream: one word per input word with the root
// estimate, the number of estimates computed and a status code
// (converged, no sign change, limit reached, zero denominator).
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_idx_i
// (0 tolerance, 1 iteration limit); write only while the block is idle.
// Steps: the square and the cube of each end value, then for each estimate
// the denominator test, the split numerator product, the bit-serial
// divider (25 quotient bits), forming the estimate and the compare; each
// further estimate first takes the square and cube of the latest estimate
// and picks the side.
// One item is worked on at a time; the next input word is taken in the
// cycle after the result is registered.
// The result sits in an output register; the next input word is taken while
// it waits, and a stalled receiver holds the word until tready rises.
// Reset clears the control state, the output valid, and sets the tolerance
// to 7 and the limit to 20.
module regula_falsi_cubic_root
  import rfcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // left_end, right_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // root, iterations, status, zero pad
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [TolW-1:0]      tol_q;
  logic [ItrW-1:0]      limit_q;
  rfcr_cmd_t            cmd;
  rfcr_stat_t           stat;
  logic signed [XW-1:0] x0, est, root;
  logic [ItrW-1:0]      iters;
  rfcr_status_e         status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= 16'd7;
      limit_q <= 5'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTol:   tol_q   <= cfg_data_i;
        CfgLimit: limit_q <= cfg_data_i[ItrW-1:0];
        default: ;
      endcase
    end
  end

  rfcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_root_o   (root),
    .m_iter_o   (iters),
    .m_status_o (status),
    .limit_i    (limit_q),
    .stat_i     (stat),
    .x0_i       (x0),
    .est_i      (est),
    .cmd_o      (cmd)
  );

  rfcr_datapath u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .left_i  (s_axis_tdata[23:0]),
    .right_i (s_axis_tdata[47:24]),
    .tol_i   (tol_q),
    .stat_o  (stat),
    .x0_o    (x0),
    .est_o   (est)
  );

  // result word packing
  assign m_axis_tdata = {1'b0, status, iters, root};

endmodule

// ===== hdl/rfcr_checker.sv =====
`include "regula_falsi_cubic_root_defines.svh"

module rfcr_checker
  import rfcr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // no sign change gives a word with zero root and zero iteration count
  `RFCR_ASSERT(a_nosign_zero, m_axis_tvalid && m_axis_tdata[30:29] == ST_NO_SIGN |-> m_axis_tdata[28:0] == 29'd0, "no sign change word not zero")

  // convergence or limit needs at least two estimates
  `RFCR_ASSERT(a_two_est, m_axis_tvalid && (m_axis_tdata[30:29] == ST_CONVERGED || m_axis_tdata[30:29] == ST_LIMIT) |-> m_axis_tdata[28:24] >= 5'd2, "too few estimates")

  // stalled word holds
  `RFCR_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")

  // nothing offered in reset
  `RFCR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "valid during reset")

endmodule

bind regula_falsi_cubic_root rfcr_checker u_rfcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
